// File: hdl/nvlu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvlu_pkg
// shared types and constants for the nearest vertex attribute lookup
// ----------------------------------------------------------------------------
package nvlu_pkg;

  // fixed field widths of the ports
  localparam int COMP_W = 16;  // one coordinate or direction component
  localparam int IDX_W  = 10;  // entry index on the ports
  localparam int CNT_W  = 11;  // vertex count register

  // defaults for the top level parameters
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_RESULT
  } nvlu_state_e;

endpackage

// File: hdl/nvlu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvlu_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nvlu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/nearest_vertex_attribute_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_vertex_attribute_lookup
// brute force 3d nearest neighbor search over a vertex table with attributes
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | carries
//   --------+-----------+--------------------------+-------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o  | vertex_count
//   in      | in        | in_valid_i/in_ready_o    | kind, entry_index, coords, dirs
//   out     | out       | out_valid_o/out_ready_i  | found, nearest_index, dirs
//
// a load writes the vertex ram and the direction ram at the edge of its
// transfer and leaves the block idle.
// a query scans n = min(vertex_count, MAX_VERTICES) entries: the scan reads
// one vertex per cycle through the single read port of the vertex ram, then
// the drain state empties the distance pipeline, the fetch state reads the
// direction ram and the result state loads the result; n = 0 goes to result.
// reset clears control state only; the rams come up undefined and need no
// clearing pass. the result register holds a finished result while loads
// continue; a following query scans but waits to post until the slot frees.
// ----------------------------------------------------------------------------
module nearest_vertex_attribute_lookup
  import nvlu_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_vertex_count_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [COMP_W-1:0] coord_x_i,
  input  logic signed [COMP_W-1:0] coord_y_i,
  input  logic signed [COMP_W-1:0] coord_z_i,
  input  logic signed [COMP_W-1:0] max_dir_x_i,
  input  logic signed [COMP_W-1:0] max_dir_y_i,
  input  logic signed [COMP_W-1:0] max_dir_z_i,
  input  logic signed [COMP_W-1:0] min_dir_x_i,
  input  logic signed [COMP_W-1:0] min_dir_y_i,
  input  logic signed [COMP_W-1:0] min_dir_z_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [IDX_W-1:0]         nearest_index_o,
  output logic signed [COMP_W-1:0] out_max_x_o,
  output logic signed [COMP_W-1:0] out_max_y_o,
  output logic signed [COMP_W-1:0] out_max_z_o,
  output logic signed [COMP_W-1:0] out_min_x_o,
  output logic signed [COMP_W-1:0] out_min_y_o,
  output logic signed [COMP_W-1:0] out_min_z_o
);

  // address, count and arithmetic widths
  localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int EXT_W  = (COORD_BITS > COMP_W) ? COORD_BITS : COMP_W;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int VTX_W  = 3 * COMP_W;
  localparam int DIR_W  = 6 * COMP_W;

  // low COORD_BITS of a stored component, read as signed
  function automatic logic signed [COORD_BITS-1:0] coord_val(input logic [COMP_W-1:0] raw);
    logic [EXT_W-1:0] z;
    z = EXT_W'(raw);
    return $signed(z[COORD_BITS-1:0]);
  endfunction

  nvlu_state_e state_q, state_d;

  // configuration
  logic [CNT_W-1:0] cfg_count_q;

  // query context
  logic signed [COORD_BITS-1:0] q_x_q, q_y_q, q_z_q;
  logic [CW-1:0]                limit_q, limit_d;
  logic [CW-1:0]                issue_cnt_q, issue_cnt_d;

  // distance pipeline
  logic                rd_valid_q;
  logic [AW-1:0]       rd_idx_q;
  logic                sq_valid_q;
  logic [AW-1:0]       sq_idx_q;
  logic [SQ_W-1:0]     sq_x_q, sq_y_q, sq_z_q;
  logic [DIST_W-1:0]   dist_sum;
  logic                have_q, have_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic [DIST_W-1:0]   best_dist_q, best_dist_d;

  // ram ports
  logic                vtx_we;
  logic [AW-1:0]       vtx_waddr;
  logic [VTX_W-1:0]    vtx_wdata;
  logic                vtx_re;
  logic [AW-1:0]       vtx_raddr;
  logic [VTX_W-1:0]    vtx_rdata;
  logic                dir_re;
  logic [DIR_W-1:0]    dir_wdata;
  logic [DIR_W-1:0]    dir_rdata;

  // handshakes
  logic in_xfer;
  logic query_xfer;
  logic load_in_range;
  logic out_load;
  logic out_valid_q;
  logic scan_last;
  logic pipe_empty;

  // result register
  logic                     found_q;
  logic [IDX_W-1:0]         idx_q;
  logic [DIR_W-1:0]         dirs_q;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign query_xfer  = in_xfer && (kind_i == KIND_QUERY);
  assign scan_last   = (issue_cnt_q == limit_q - CW'(1));
  assign pipe_empty  = !rd_valid_q && !sq_valid_q;

  // loads out of table range are dropped
  assign load_in_range = (32'(entry_index_i) < MAX_VERTICES);
  assign vtx_we        = in_xfer && (kind_i == KIND_LOAD) && load_in_range;
  assign vtx_waddr     = AW'(entry_index_i);
  assign vtx_wdata     = {coord_z_i, coord_y_i, coord_x_i};
  assign dir_wdata     = {min_dir_z_i, min_dir_y_i, min_dir_x_i,
                          max_dir_z_i, max_dir_y_i, max_dir_x_i};

  nvlu_ram #(
    .WIDTH(VTX_W),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (vtx_we),
    .waddr_i(vtx_waddr),
    .wdata_i(vtx_wdata),
    .re_i   (vtx_re),
    .raddr_i(vtx_raddr),
    .rdata_o(vtx_rdata)
  );

  // both direction vectors of an entry share one word
  nvlu_ram #(
    .WIDTH(DIR_W),
    .DEPTH(MAX_VERTICES)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (vtx_we),
    .waddr_i(vtx_waddr),
    .wdata_i(dir_wdata),
    .re_i   (dir_re),
    .raddr_i(best_idx_q),
    .rdata_o(dir_rdata)
  );

  // scan length clamps to the table size
  always_comb begin
    if (32'(cfg_count_q) > MAX_VERTICES) begin
      limit_d = CW'(MAX_VERTICES);
    end else begin
      limit_d = CW'(cfg_count_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_xfer) begin
          state_d = (limit_d == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = 1'b0;
    vtx_re      = 1'b0;
    vtx_raddr   = issue_cnt_q[AW-1:0];
    issue_cnt_d = issue_cnt_q;
    dir_re      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        issue_cnt_d = '0;
      end
      ST_SCAN: begin
        vtx_re      = 1'b1;
        issue_cnt_d = issue_cnt_q + CW'(1);
      end
      ST_FETCH: begin
        dir_re = 1'b1;
      end
      ST_RESULT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // squared distance per axis, registered after the multipliers
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [SQ_W-1:0]   px, py, pz;

  always_comb begin
    dx = DIFF_W'(coord_val(vtx_rdata[COMP_W-1:0]))          - DIFF_W'(q_x_q);
    dy = DIFF_W'(coord_val(vtx_rdata[2*COMP_W-1:COMP_W]))   - DIFF_W'(q_y_q);
    dz = DIFF_W'(coord_val(vtx_rdata[3*COMP_W-1:2*COMP_W])) - DIFF_W'(q_z_q);
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  // running minimum, strict compare keeps the lowest index on ties
  assign dist_sum = DIST_W'(sq_x_q) + DIST_W'(sq_y_q) + DIST_W'(sq_z_q);

  always_comb begin
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    if (query_xfer) begin
      have_d = 1'b0;
    end else if (sq_valid_q && (!have_q || (dist_sum < best_dist_q))) begin
      have_d      = 1'b1;
      best_idx_d  = sq_idx_q;
      best_dist_d = dist_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_count_q <= '0;
      issue_cnt_q <= '0;
      rd_valid_q  <= 1'b0;
      sq_valid_q  <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      rd_valid_q  <= vtx_re;
      sq_valid_q  <= rd_valid_q;
      have_q      <= have_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_count_q <= cfg_vertex_count_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      q_x_q   <= coord_val(coord_x_i);
      q_y_q   <= coord_val(coord_y_i);
      q_z_q   <= coord_val(coord_z_i);
      limit_q <= limit_d;
    end
    rd_idx_q    <= vtx_raddr;
    sq_idx_q    <= rd_idx_q;
    sq_x_q      <= px;
    sq_y_q      <= py;
    sq_z_q      <= pz;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    if (out_load) begin
      found_q <= have_q;
      idx_q   <= have_q ? IDX_W'(best_idx_q) : '0;
      dirs_q  <= have_q ? dir_rdata : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign nearest_index_o = idx_q;
  assign out_max_x_o     = dirs_q[COMP_W-1:0];
  assign out_max_y_o     = dirs_q[2*COMP_W-1:COMP_W];
  assign out_max_z_o     = dirs_q[3*COMP_W-1:2*COMP_W];
  assign out_min_x_o     = dirs_q[4*COMP_W-1:3*COMP_W];
  assign out_min_y_o     = dirs_q[5*COMP_W-1:4*COMP_W];
  assign out_min_z_o     = dirs_q[6*COMP_W-1:5*COMP_W];

endmodule

// File: hdl/nvlu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvlu_checker
// port level checks for the nearest vertex attribute lookup
// ----------------------------------------------------------------------------
module nvlu_checker
  import nvlu_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     kind_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     found_o,
  input logic [IDX_W-1:0]         nearest_index_o,
  input logic signed [COMP_W-1:0] out_max_x_o,
  input logic signed [COMP_W-1:0] out_max_y_o,
  input logic signed [COMP_W-1:0] out_max_z_o,
  input logic signed [COMP_W-1:0] out_min_x_o,
  input logic signed [COMP_W-1:0] out_min_y_o,
  input logic signed [COMP_W-1:0] out_min_z_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(nearest_index_o) && $stable(out_max_x_o) && $stable(out_min_z_o))
    else $error("result changed while stalled");

  // an empty scan reports all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> nearest_index_o == '0 && out_max_x_o == '0
      && out_max_y_o == '0 && out_max_z_o == '0 && out_min_x_o == '0
      && out_min_y_o == '0 && out_min_z_o == '0)
    else $error("empty result not zero");

  // a load never causes a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("result after load");

  // a query drops input ready in the cycle after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_QUERY |=> !in_ready_o)
    else $error("input ready right after query");

endmodule

bind nearest_vertex_attribute_lookup nvlu_checker u_nvlu_checker (.*);

// File: sim/tb_nearest_vertex_attribute_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_vertex_attribute_lookup
// self-checking bench for the nearest vertex attribute lookup: loads vertices
// and their two curvature directions into the table, sends query points and
// checks every returned index and direction pair against an exhaustive scan
// of a shadow copy of the table, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_nearest_vertex_attribute_lookup
  import nvlu_pkg::*;
();

  localparam int TABLE_DEPTH   = MAX_VERTICES_DEF;
  localparam int MAX_GAP       = 18;
  // a load is written at the edge of its transfer, so a short pause is plenty
  localparam int SETTLE_CYCLES = 16;
  // longest legal quiet stretch is a full 1024 entry scan plus both idle gaps
  localparam int STALL_LIMIT   = 6000;
  localparam int RANDOM_ROUNDS = 20;
  localparam int ROUND_ITEMS   = 20;

  typedef logic [2:0][COMP_W-1:0] vec3_t;  // [0] = x, [1] = y, [2] = z

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] entry_index;
    vec3_t            coord;
    vec3_t            max_dir;
    vec3_t            min_dir;
  } vertex_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] nearest_index;
    vec3_t            max_dir;
    vec3_t            min_dir;
  } lookup_result_t;

  // how far apart random coordinates fall: tight spreads make many ties
  typedef enum int {
    SPREAD_FULL,
    SPREAD_CLUSTER,
    SPREAD_TIGHT
  } spread_e;

  // --------------------------------------------------------------------------
  // scoreboard: shadow table, register copy and queue of expected results
  // --------------------------------------------------------------------------
  class nearest_lookup_sb;
    logic [CNT_W-1:0] vertex_count;
    vec3_t            pos_table [TABLE_DEPTH];
    vec3_t            max_table [TABLE_DEPTH];
    vec3_t            min_table [TABLE_DEPTH];
    lookup_result_t   pending_lookups [$];
    int unsigned      errors;

    function new();
      vertex_count = '0;
      errors       = 0;
    endfunction

    // exhaustive scan; strict less-than keeps the lowest index on a tie
    function lookup_result_t find_nearest(vec3_t point);
      lookup_result_t r;
      int unsigned    scan_len;
      int unsigned    best;
      longint         best_dist;
      longint         sq_sum;
      longint         diff;
      r         = '0;
      best      = 0;
      best_dist = 0;
      // counts above the table size scan the whole table
      scan_len  = (vertex_count > TABLE_DEPTH) ? TABLE_DEPTH : vertex_count;
      for (int unsigned i = 0; i < scan_len; i++) begin
        sq_sum = 0;
        for (int k = 0; k < 3; k++) begin
          diff = longint'($signed(pos_table[i][k])) - longint'($signed(point[k]));
          sq_sum += diff * diff;
        end
        if (i == 0 || sq_sum < best_dist) begin
          best_dist = sq_sum;
          best      = i;
        end
      end
      // empty scan leaves every field at zero
      if (scan_len != 0) begin
        r.found         = 1'b1;
        r.nearest_index = best[IDX_W-1:0];
        r.max_dir       = max_table[best];
        r.min_dir       = min_table[best];
      end
      return r;
    endfunction

    function void note_transfer(vertex_item_t it);
      if (it.kind == KIND_LOAD) begin
        pos_table[it.entry_index] = it.coord;
        max_table[it.entry_index] = it.max_dir;
        min_table[it.entry_index] = it.min_dir;
      end else begin
        pending_lookups.insert(pending_lookups.size(), find_nearest(it.coord));
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        $display("%0t: result with no query outstanding, expected none, actual index %0d",
                 $time, got.nearest_index);
        errors++;
        return;
      end
      want = pending_lookups.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("nearest_index", want.nearest_index, got.nearest_index);
      for (int k = 0; k < 3; k++) begin
        compare_field($sformatf("out_max[%0d]", k), $signed(want.max_dir[k]),
                      $signed(got.max_dir[k]));
        compare_field($sformatf("out_min[%0d]", k), $signed(want.min_dir[k]),
                      $signed(got.min_dir[k]));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CNT_W-1:0]         cfg_vertex_count_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     kind_i;
  logic [IDX_W-1:0]         entry_index_i;
  logic signed [COMP_W-1:0] coord_x_i;
  logic signed [COMP_W-1:0] coord_y_i;
  logic signed [COMP_W-1:0] coord_z_i;
  logic signed [COMP_W-1:0] max_dir_x_i;
  logic signed [COMP_W-1:0] max_dir_y_i;
  logic signed [COMP_W-1:0] max_dir_z_i;
  logic signed [COMP_W-1:0] min_dir_x_i;
  logic signed [COMP_W-1:0] min_dir_y_i;
  logic signed [COMP_W-1:0] min_dir_z_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     found_o;
  logic [IDX_W-1:0]         nearest_index_o;
  logic signed [COMP_W-1:0] out_max_x_o;
  logic signed [COMP_W-1:0] out_max_y_o;
  logic signed [COMP_W-1:0] out_max_z_o;
  logic signed [COMP_W-1:0] out_min_x_o;
  logic signed [COMP_W-1:0] out_min_y_o;
  logic signed [COMP_W-1:0] out_min_z_o;

  nearest_vertex_attribute_lookup dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .entry_index_i      (entry_index_i),
    .coord_x_i          (coord_x_i),
    .coord_y_i          (coord_y_i),
    .coord_z_i          (coord_z_i),
    .max_dir_x_i        (max_dir_x_i),
    .max_dir_y_i        (max_dir_y_i),
    .max_dir_z_i        (max_dir_z_i),
    .min_dir_x_i        (min_dir_x_i),
    .min_dir_y_i        (min_dir_y_i),
    .min_dir_z_i        (min_dir_z_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .found_o            (found_o),
    .nearest_index_o    (nearest_index_o),
    .out_max_x_o        (out_max_x_o),
    .out_max_y_o        (out_max_y_o),
    .out_max_z_o        (out_max_z_o),
    .out_min_x_o        (out_min_x_o),
    .out_min_y_o        (out_min_y_o),
    .out_min_z_o        (out_min_z_o)
  );

  nearest_lookup_sb sb;
  bit               sender_steady = 1'b0;  // stretch with no gaps on input
  bit               sink_steady   = 1'b0;  // stretch with no stalls on output

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------
  function automatic vec3_t vec3(int x, int y, int z);
    vec3_t v;
    v[0] = COMP_W'(x);
    v[1] = COMP_W'(y);
    v[2] = COMP_W'(z);
    return v;
  endfunction

  // direction components stay inside -1.0 .. +1.0 in q1.14
  function automatic vec3_t random_dir();
    vec3_t v;
    for (int k = 0; k < 3; k++) v[k] = COMP_W'($urandom_range(0, 32768) - 16384);
    return v;
  endfunction

  function automatic vec3_t random_pos(spread_e spread);
    vec3_t v;
    for (int k = 0; k < 3; k++) begin
      case (spread)
        SPREAD_TIGHT:   v[k] = COMP_W'($urandom_range(0, 4) - 2);
        SPREAD_CLUSTER: v[k] = COMP_W'($urandom_range(0, 255) - 128);
        default:        v[k] = COMP_W'($urandom_range(0, 65535));
      endcase
    end
    return v;
  endfunction

  function automatic vertex_item_t load_item(logic [IDX_W-1:0] idx, vec3_t pos,
                                             vec3_t max_dir, vec3_t min_dir);
    vertex_item_t it;
    it.kind        = KIND_LOAD;
    it.entry_index = idx;
    it.coord       = pos;
    it.max_dir     = max_dir;
    it.min_dir     = min_dir;
    return it;
  endfunction

  // a query ignores index and directions, so they carry random noise
  function automatic vertex_item_t query_item(vec3_t point);
    vertex_item_t it;
    it.kind        = KIND_QUERY;
    it.entry_index = IDX_W'($urandom_range(0, 1023));
    it.coord       = point;
    it.max_dir     = random_dir();
    it.min_dir     = random_dir();
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers: inputs move on the falling edge, transfers are seen on
  // the rising edge
  // --------------------------------------------------------------------------
  task automatic send_item(input vertex_item_t it);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i        = it.kind;
    entry_index_i = it.entry_index;
    coord_x_i     = it.coord[0];
    coord_y_i     = it.coord[1];
    coord_z_i     = it.coord[2];
    max_dir_x_i   = it.max_dir[0];
    max_dir_y_i   = it.max_dir[1];
    max_dir_z_i   = it.max_dir[2];
    min_dir_x_i   = it.min_dir[0];
    min_dir_y_i   = it.min_dir[1];
    min_dir_z_i   = it.min_dir[2];
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_transfer(it);
  endtask

  // sender holds off until every outstanding query has come back
  task automatic wait_lookups_done();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_lookups.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register writes happen only with the block idle
  task automatic write_vertex_count(input logic [CNT_W-1:0] value);
    wait_lookups_done();
    @(negedge clk_i);
    cfg_vertex_count_i = value;
    cfg_valid_i        = 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.vertex_count = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // result side: random stalls, every transfer checked against the queue
  initial begin : result_sink
    int unsigned    gap;
    lookup_result_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
      gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.found         = found_o;
      got.nearest_index = nearest_index_o;
      got.max_dir       = {out_max_z_o, out_max_y_o, out_max_x_o};
      got.min_dir       = {out_min_z_o, out_min_y_o, out_min_x_o};
      sb.check_result(got);
    end
  end

  // watchdog: any transfer on any channel restarts the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i === 1'b1) ||
          (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned      count;
    spread_e          spread;
    vec3_t            point;
    logic [IDX_W-1:0] idx;

    sb                 = new();
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_vertex_count_i = '0;
    in_valid_i         = 1'b0;
    kind_i             = KIND_LOAD;
    entry_index_i      = '0;
    coord_x_i          = '0;
    coord_y_i          = '0;
    coord_z_i          = '0;
    max_dir_x_i        = '0;
    max_dir_y_i        = '0;
    max_dir_z_i        = '0;
    min_dir_x_i        = '0;
    min_dir_y_i        = '0;
    min_dir_z_i        = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: count is zero out of reset, so this is an empty scan
    send_item(query_item(vec3(-32768, -32768, -32768)));

    // corner vertices, a duplicate of entry 1 for a tie, the origin,
    // and the top entry of the table
    send_item(load_item(10'd0, vec3(-32768, -32768, -32768),
                        vec3(16384, -16384, 16384), vec3(-16384, 16384, -16384)));
    send_item(load_item(10'd1, vec3(32767, 32767, 32767),
                        vec3(-16384, 0, 1), vec3(-1, 16384, 0)));
    send_item(load_item(10'd2, vec3(32767, 32767, 32767),
                        vec3(1, 2, 3), vec3(4, 5, 6)));
    send_item(load_item(10'd3, vec3(0, 0, 0), random_dir(), random_dir()));
    send_item(load_item(10'd1023, vec3(-1, 256, -256), random_dir(), random_dir()));

    write_vertex_count(11'd4);
    send_item(query_item(vec3(32767, 32767, 32767)));      // tie, entry 1 wins
    send_item(query_item(vec3(-32768, -32768, -32768)));   // exact hit on entry 0
    send_item(query_item(vec3(0, 0, 0)));                  // exact hit on entry 3
    send_item(query_item(vec3(-32768, 32767, -32768)));    // widest differences
    send_item(query_item(vec3(16384, 16384, 16384)));      // entry 1 by one lsb
    send_item(query_item(vec3(-16384, -16384, -16384)));   // tie 0 vs 3, entry 0 wins
    send_item(load_item(10'd3, vec3(5, 5, 5), random_dir(), random_dir()));
    send_item(query_item(vec3(5, 5, 5)));                  // sees the overwrite

    write_vertex_count(11'd1);
    send_item(query_item(vec3(32767, 32767, 32767)));      // single entry scanned
    write_vertex_count(11'd0);
    send_item(query_item(random_pos(SPREAD_FULL)));        // empty scan again

    // fill the whole table so that full and oversized counts are legal
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      send_item(load_item(IDX_W'(e), random_pos(spread_e'($urandom_range(0, 2))),
                          random_dir(), random_dir()));
    end
    write_vertex_count(11'd1024);
    repeat (2) send_item(query_item(random_pos(SPREAD_FULL)));
    // counts beyond the table size clamp to the table size
    write_vertex_count(11'd2047);
    repeat (2) send_item(query_item(random_pos(SPREAD_FULL)));
    write_vertex_count(11'd1025);
    send_item(query_item(random_pos(SPREAD_FULL)));

    // random rounds: mostly short scans, one register setting per round
    for (int round_no = 0; round_no < RANDOM_ROUNDS; round_no++) begin
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = $urandom_range(64, 256);
        default: count = $urandom_range(1, 24);
      endcase
      write_vertex_count(CNT_W'(count));
      spread = spread_e'($urandom_range(0, 2));
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 6) begin
          // some queries land exactly on a scanned vertex
          if (count != 0 && $urandom_range(0, 3) == 0)
            point = sb.pos_table[$urandom_range(0, count - 1)];
          else
            point = random_pos(spread);
          send_item(query_item(point));
        end else begin
          // loads mostly hit the scanned range so queries see fresh data
          if ($urandom_range(0, 4) == 0)
            idx = IDX_W'($urandom_range(0, 1023));
          else
            idx = IDX_W'($urandom_range(0, count + 3));
          send_item(load_item(idx, random_pos(spread), random_dir(), random_dir()));
        end
      end
    end

    wait_lookups_done();
    if (sb.errors == 0 && sb.pending_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
